@@ hdl/dq_pkg.sv @@
`default_nettype none

package dq_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic accept;  // latch incoming beat
    logic exec;    // update pointers, write slot
    logic read;    // read front and back slots
    logic load;    // fill output register
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/dq_ctrl.sv @@
`default_nettype none

module dq_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output dq_pkg::cmd_t     cmd_o
);

  import dq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/dq_datapath.sv @@
`default_nettype none

module dq_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PTR_W = $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire dq_pkg::cmd_t                       cmd_i,
  input  wire logic [dq_pkg::FUNC_W-1:0]          func_i,
  input  wire logic signed [dq_pkg::VALUE_W-1:0]  value_i,
  output logic                                    error_o,
  output logic                                    is_empty_o,
  output logic signed [dq_pkg::VALUE_W-1:0]       front_value_o,
  output logic signed [dq_pkg::VALUE_W-1:0]       back_value_o,
  output logic [CNT_W-1:0]                        count_o
);

  import dq_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [FUNC_W-1:0]  func_q;
  logic [VALUE_W-1:0] value_q;
  logic [PTR_W-1:0]   front_q, front_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               err_q, err_d;
  logic [VALUE_W-1:0] rd_front_q, rd_back_q;

  logic               full, empty;
  logic [PTR_W-1:0]   front_dec, front_inc, tail_idx, back_idx;
  logic [SUM_W-1:0]   tail_sum, back_sum;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_idx;

  assign full  = (fill_q == CNT_W'(DEPTH));
  assign empty = (fill_q == '0);

  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  // slot after the back: front + fill, wrapped
  assign tail_sum = SUM_W'(front_q) + SUM_W'(fill_q);
  always_comb begin
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_idx = PTR_W'(tail_sum - SUM_W'(DEPTH));
    end else begin
      tail_idx = PTR_W'(tail_sum);
    end
  end

  // back slot: front + fill - 1, wrapped; unused when empty
  assign back_sum = SUM_W'(front_q) + SUM_W'(fill_q) - 1'b1;
  always_comb begin
    if (back_sum >= SUM_W'(DEPTH)) begin
      back_idx = PTR_W'(back_sum - SUM_W'(DEPTH));
    end else begin
      back_idx = PTR_W'(back_sum);
    end
  end

  always_comb begin
    front_d = front_q;
    fill_d  = fill_q;
    err_d   = err_q;
    wr_en   = 1'b0;
    wr_idx  = tail_idx;
    if (cmd_i.exec) begin
      err_d = 1'b0;
      case (op_e'(func_q))
        OP_PUSH_FRONT: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_idx  = front_dec;
            front_d = front_dec;
            fill_d  = fill_q + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_idx = tail_idx;
            fill_d = fill_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            err_d = 1'b1;
          end else begin
            front_d = front_inc;
            fill_d  = fill_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      fill_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      fill_q  <= fill_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_front_q <= mem[front_q];
      rd_back_q  <= mem[back_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      error_o       <= err_q;
      is_empty_o    <= empty;
      front_value_o <= empty ? '0 : $signed(rd_front_q);
      back_value_o  <= empty ? '0 : $signed(rd_back_q);
      count_o       <= fill_q;
    end
  end

endmodule

`default_nettype wire

@@ hdl/double_ended_queue.sv @@
`default_nettype none

// channel  dir  tdata (low bit up)                    tuser (low bit up)
// s_axis   in   value[31:0]                           func[1:0]
// m_axis   out  front_value, back_value, count, pad   error, is_empty
//
// Each beat passes through capture, slot write and pointer update,
// registered two-port slot read and output load.
// A new beat is taken while an earlier result still waits on m_axis; it stalls
// in the load step until the output register frees up.
// Reset clears the pointers, the fill count, the error flag, the controller
// state and the output valid flag; slot contents stay undefined until written.

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         s_axis_tvalid,
  output logic                                              s_axis_tready,
  input  wire logic [31:0]                                  s_axis_tdata,  // value
  input  wire logic [1:0]                                   s_axis_tuser,  // func
  output logic                                              m_axis_tvalid,
  input  wire logic                                         m_axis_tready,
  // front_value, back_value, count, zero pad
  output logic [((64 + $clog2(DEPTH + 1) + 7) / 8) * 8-1:0] m_axis_tdata,
  output logic [1:0]                                        m_axis_tuser   // error, is_empty
);

  import dq_pkg::*;

  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TDATA_W = ((2 * VALUE_W + CNT_W + 7) / 8) * 8;

  cmd_t                      cmd;
  logic                      error, is_empty;
  logic signed [VALUE_W-1:0] front_value, back_value;
  logic [CNT_W-1:0]          count;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (s_axis_tuser),
    .value_i       ($signed(s_axis_tdata)),
    .error_o       (error),
    .is_empty_o    (is_empty),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .count_o       (count)
  );

  assign m_axis_tdata = TDATA_W'({count, back_value, front_value});
  assign m_axis_tuser = {is_empty, error};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
  import dq_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned CNT_W           = $clog2(DEPTH + 1);
  localparam int unsigned M_TDATA_W       = ((2 * VALUE_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned ITEMS_PER_PHASE = 440;

  typedef struct packed {
    logic               error;
    logic               is_empty;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [CNT_W-1:0]   count;
  } status_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [VALUE_W-1:0]   s_axis_tdata  = '0;  // value
  logic [FUNC_W-1:0]    s_axis_tuser  = OP_NONE;  // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // front_value, back_value, count, pad
  logic [1:0]           m_axis_tuser;  // error, is_empty

  // deque shadow: circular buffer, head slot and fill level
  logic [VALUE_W-1:0] shadow_slots [DEPTH];
  int unsigned        shadow_head = 0;
  int unsigned        shadow_fill = 0;
  status_t            pending_status [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned error_results  = 0;
  int unsigned full_results   = 0;
  int unsigned empty_results  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding", $time,
               CYCLE_LIMIT, pending_status.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic status_t deque_step(op_e op, logic [VALUE_W-1:0] val);
    status_t st;
    st = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          st.error = 1'b1;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_head] = val;
          shadow_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          st.error = 1'b1;
        end else begin
          shadow_slots[(shadow_head + shadow_fill) % DEPTH] = val;
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          st.error = 1'b1;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      default: ;
    endcase
    st.is_empty = (shadow_fill == 0);
    st.count    = shadow_fill[CNT_W-1:0];
    if (shadow_fill != 0) begin
      st.front_value = shadow_slots[shadow_head];
      st.back_value  = shadow_slots[(shadow_head + shadow_fill - 1) % DEPTH];
    end
    return st;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.error       = m_axis_tuser[0];
      got.is_empty    = m_axis_tuser[1];
      got.front_value = m_axis_tdata[VALUE_W-1:0];
      got.back_value  = m_axis_tdata[2*VALUE_W-1:VALUE_W];
      got.count       = m_axis_tdata[2*VALUE_W +: CNT_W];
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        check_field("error", VALUE_W'(want.error), VALUE_W'(got.error));
        check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
        check_field("front_value", want.front_value, got.front_value);
        check_field("back_value", want.back_value, got.back_value);
        check_field("count", VALUE_W'(want.count), VALUE_W'(got.count));
        if (want.error) error_results++;
        if (want.count == DEPTH) full_results++;
        if (want.is_empty) empty_results++;
      end
    end
  end

  task automatic send_beat(op_e op, logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_status.insert(pending_status.size(), deque_step(op, val));
    beats_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // empty-queue errors, extreme values, head index wrapping below zero
  task automatic test_empty_edges();
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_NONE, 32'hFFFF_FFFF);
    send_beat(OP_PUSH_FRONT, 32'h8000_0000);
    send_beat(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_beat(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_beat(OP_NONE, 32'h1234_5678);
    send_beat(OP_POP_FRONT, 32'hA5A5_A5A5);
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_PUSH_BACK, 32'h0000_0000);
    send_beat(OP_PUSH_BACK, 32'h0000_0001);
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_POP_FRONT, 32'h0000_0000);
    send_beat(OP_POP_FRONT, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_and_wrap();
    for (int i = 0; i < DEPTH; i++)
      send_beat(op_e'((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK), $urandom());
    send_beat(OP_PUSH_FRONT, 32'h8000_0000);
    send_beat(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_beat(OP_NONE, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++)
      send_beat(OP_POP_FRONT, $urandom());
    send_beat(OP_POP_FRONT, 32'h0000_0000);
  endtask

  // runs of fill-biased, drain-biased and balanced traffic so the queue
  // swings between empty and full
  task automatic test_random_ops(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned trend;
    int unsigned r;
    op_e op;
    logic [VALUE_W-1:0] val;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    trend = 2;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) trend = $urandom_range(2);
      if (i == n / 2) begin
        stop_sending();
        wait_drained();
      end
      r = $urandom_range(99);
      case (trend)
        0:       op = op_e'((r < 45) ? OP_PUSH_FRONT : (r < 85) ? OP_PUSH_BACK :
                            (r < 95) ? OP_POP_FRONT : OP_NONE);
        1:       op = op_e'((r < 10) ? OP_PUSH_FRONT : (r < 20) ? OP_PUSH_BACK :
                            (r < 92) ? OP_POP_FRONT : OP_NONE);
        default: op = op_e'((r < 25) ? OP_PUSH_FRONT : (r < 50) ? OP_PUSH_BACK :
                            (r < 90) ? OP_POP_FRONT : OP_NONE);
      endcase
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom();
      endcase
      send_beat(op, val);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_edges();
    test_full_and_wrap();
    test_random_ops(ITEMS_PER_PHASE, 0, 0);
    test_random_ops(ITEMS_PER_PHASE, 80, 0);
    test_random_ops(ITEMS_PER_PHASE, 0, 80);
    test_random_ops(ITEMS_PER_PHASE, 35, 35);
    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run: %0d beats in, %0d results checked over four handshake phases",
             beats_sent, results_seen);
    $display("Coverage: %0d error results, %0d at full depth, %0d with empty queue",
             error_results, full_results, empty_results);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/double_ended_queue.sv
tb/sv/tb_top.sv
